FILE: design/ngh_pkg.sv
package ngh_pkg;

  localparam int NUM_OPCODES = 64;
  localparam int OPC_W       = $clog2(NUM_OPCODES);
  localparam int MAX_HIST    = 3;
  localparam int IDX_W       = OPC_W * MAX_HIST;
  localparam int STORE_DEPTH = 2 ** IDX_W;
  localparam int HL_W        = 2;
  localparam int OP_W        = 2;
  localparam int OUT_W       = 32;
  localparam int COUNT_W_DEF = 32;
  localparam int LEN_SH_W    = $clog2(IDX_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic finish;
  } ngh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic needs_mem;
    logic can_finish;
  } ngh_sts_t;

endpackage

FILE: design/ngh_in_if.sv
interface ngh_in_if import ngh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [OPC_W-1:0]  opcode;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, output op, output opcode, output read_index, input ready);
  modport sink (input valid, input op, input opcode, input read_index, output ready);
endinterface

FILE: design/ngh_out_if.sv
interface ngh_out_if import ngh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  count;
  logic [IDX_W-1:0]  index_echo;

  modport source (output valid, output count, output index_echo, input ready);
  modport sink (input valid, input count, input index_echo, output ready);
endinterface

FILE: design/opcode_ngram_histogram_core.sv
// channel  dir  payload                          transfer
// in_ch    in   op, opcode, read_index           valid && ready
// out_ch   out  count, index_echo                valid && ready
// cfg      in   cfg_wdata (history length)       cfg_we
//
// count and read items take a counter store read, then a write or result
// start and unused op codes need no counter store access; the counter store has a single write port
// after reset a clearing pass zeroes the whole store, no items taken
// a read waits in its update state while the output register is still held
// rst_n is synchronous, active low
module opcode_ngram_histogram_core import ngh_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ngh_in_if.sink          in_ch,
  ngh_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [HL_W-1:0] cfg_wdata
);

  ngh_cmd_t cmd;
  ngh_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  ngh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ngh_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_ch.op),
    .in_opcode     (in_ch.opcode),
    .in_read_index (in_ch.read_index),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .sts           (sts),
    .out_ch        (out_ch)
  );

endmodule

FILE: design/ngh_ram.sv
module ngh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ngh_ctrl.sv
module ngh_ctrl import ngh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ngh_sts_t sts,
  output ngh_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.clr_step = 1'b0;
    cmd.accept   = 1'b0;
    cmd.finish   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.needs_mem) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.finish = sts.can_finish;
        if (sts.can_finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a stalled read result keeps the update cycle open
  a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && !sts.can_finish) |=> state_r == ST_UPDATE)
    else $error("update left without finishing");

  // clearing pass must cover the whole store
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && !sts.clr_last) |=> state_r == ST_CLEAR)
    else $error("clearing pass ended early");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");

endmodule

FILE: design/ngh_dp.sv
module ngh_dp import ngh_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_op,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [IDX_W-1:0]  in_read_index,
  input  logic              cfg_we,
  input  logic [HL_W-1:0]   cfg_wdata,
  input  ngh_cmd_t          cmd,
  output ngh_sts_t          sts,
  ngh_out_if.source         out_ch
);

  logic [HL_W-1:0]        hist_len_r;
  logic [IDX_W-1:0]       window_r;
  logic [IDX_W-1:0]       window_nxt;
  logic [IDX_W-1:0]       win_shift;
  logic [IDX_W-1:0]       clr_addr_r;
  logic [IDX_W-1:0]       addr_r;
  logic [IDX_W-1:0]       gram;
  logic [IDX_W-1:0]       rd_addr;
  logic [OPC_W-1:0]       oldest;
  logic [HL_W-1:0]        hist_n;
  logic                   skip_r;
  logic                   skip;
  op_t                    op_r;
  op_t                    in_op_e;
  logic                   out_valid_r;
  logic [OUT_W-1:0]       out_count_r;
  logic [IDX_W-1:0]       out_index_r;
  logic [OUT_W-1:0]       cnt_out;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic                   out_free;

  assign in_op_e = op_t'(in_op);

  always_comb begin
    if (hist_len_r == '0) begin
      hist_n = HL_W'(1);
    end else if (int'(hist_len_r) > MAX_HIST) begin
      hist_n = HL_W'(MAX_HIST);
    end else begin
      hist_n = hist_len_r;
    end
  end

  assign win_shift = {window_r[IDX_W-OPC_W-1:0], in_opcode};
  assign gram      = win_shift & ~({IDX_W{1'b1}} << LEN_SH_W'(hist_n * OPC_W));
  assign oldest    = OPC_W'(gram >> LEN_SH_W'((hist_n - HL_W'(1)) * OPC_W));
  assign skip      = (hist_n >= HL_W'(2)) && (oldest == '0);
  assign rd_addr   = (in_op_e == OP_READ) ? in_read_index : gram;

  always_comb begin
    window_nxt = window_r;
    if (cmd.accept) begin
      case (in_op_e)
        OP_COUNT: window_nxt = win_shift;
        OP_START: window_nxt = '0;
        default:  window_nxt = window_r;
      endcase
    end
  end

  assign out_free       = !out_valid_r || out_ch.ready;
  assign sts.clr_last   = &clr_addr_r;
  assign sts.needs_mem  = (in_op_e == OP_COUNT) || (in_op_e == OP_READ);
  assign sts.can_finish = (op_r == OP_READ) ? out_free : 1'b1;

  assign ram_re    = cmd.accept && sts.needs_mem;
  assign ram_we    = cmd.clr_step ||
                     (cmd.finish && op_r == OP_COUNT && !skip_r && !(&rd_data));
  assign ram_waddr = cmd.clr_step ? clr_addr_r : addr_r;
  assign ram_wdata = cmd.clr_step ? '0 : rd_data + COUNT_WIDTH'(1);

  ngh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_out = '0;
    for (int i = 0; i < OUT_W && i < COUNT_WIDTH; i++) begin
      cnt_out[i] = rd_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r  <= HL_W'(1);
      window_r    <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_START;
    end else begin
      window_r <= window_nxt;
      if (cfg_we) begin
        hist_len_r <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      if (cmd.accept) begin
        op_r <= in_op_e;
      end
      if (cmd.finish && op_r == OP_READ) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= rd_addr;
      skip_r <= skip;
    end
    if (cmd.finish && op_r == OP_READ) begin
      out_count_r <= cnt_out;
      out_index_r <= addr_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.count      = out_count_r;
  assign out_ch.index_echo = out_index_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !cmd.accept)
    else $error("item taken during clearing pass");

  // saturation: an increment never wraps to zero
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !cmd.clr_step) |-> ram_wdata != '0)
    else $error("counter wrapped");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && op_r == OP_READ) |=> out_valid_r)
    else $error("read finished without result");

endmodule

FILE: sim/opcode_ngram_histogram_core_test.sv
`timescale 1ns / 100ps

module opcode_ngram_histogram_core_test;
  import ngh_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 92;

  // predicted n-gram counters, window and pending read results
  class gram_tally;
    typedef struct {
      bit [OUT_W-1:0] count;
      bit [IDX_W-1:0] index;
    } reading_t;

    bit [OUT_W-1:0] counters[bit [IDX_W-1:0]];
    bit [IDX_W-1:0] window;
    bit [HL_W-1:0]  hist_len;
    reading_t       expected_reads[$];
    int             errors;
    int             mismatches;
    int             reads_checked;

    function new();
      window = '0;
      hist_len = HL_W'(1);
    endfunction

    function void set_length(bit [HL_W-1:0] v);
      hist_len = v;
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [OPC_W-1:0] opc,
                            logic [IDX_W-1:0] idx);
      int unsigned    n;
      bit [IDX_W-1:0] gram;
      bit [IDX_W-1:0] mask;
      bit [OPC_W-1:0] oldest;
      reading_t       r;
      if (op == OP_COUNT) begin
        window = {window[IDX_W-OPC_W-1:0], opc};
        n = (hist_len == 0) ? 1 : ((hist_len > MAX_HIST) ? MAX_HIST : hist_len);
        mask = {IDX_W{1'b1}} >> (OPC_W * (MAX_HIST - n));
        gram = window & mask;
        oldest = OPC_W'(gram >> (OPC_W * (n - 1)));
        if (n >= 2 && oldest == 0) return;
        if (!counters.exists(gram)) counters[gram] = '0;
        if (counters[gram] != {OUT_W{1'b1}}) counters[gram] = counters[gram] + OUT_W'(1);
      end else if (op == OP_READ) begin
        r.count = counters.exists(idx) ? counters[idx] : '0;
        r.index = idx;
        expected_reads.push_back(r);
      end else if (op == OP_START) begin
        window = '0;
      end
    endfunction

    function void check_reading(logic [OUT_W-1:0] count, logic [IDX_W-1:0] idx);
      reading_t r;
      if (expected_reads.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count %0d index %h", count, idx);
        return;
      end
      r = expected_reads.pop_front();
      reads_checked++;
      if (count !== r.count || idx !== r.index) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("read mismatch: expected count %0d index %h, got count %0d index %h",
                   r.count, r.index, count, idx);
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [HL_W-1:0] cfg_wdata;

  ngh_in_if  in_ch();
  ngh_out_if out_ch();

  opcode_ngram_histogram_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  gram_tally tally = new();

  int sender_idle_pct;
  int stall_pct;
  int cycles = 0;
  int n_counts;
  int n_reads;
  int n_starts;
  int n_ignored;
  int n_lengths;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // sample both channels on the edge, results first
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        tally.check_reading(out_ch.count, out_ch.index_echo);
      if (in_ch.valid && in_ch.ready)
        tally.note_item(in_ch.op, in_ch.opcode, in_ch.read_index);
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [OPC_W-1:0] opc,
                           logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.opcode     <= opc;
    in_ch.read_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_COUNT) n_counts++;
    else if (op == OP_READ) n_reads++;
    else if (op == OP_START) n_starts++;
    else n_ignored++;
  endtask

  task automatic drain_and_set_length(logic [HL_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tally.set_length(v);
    n_lengths++;
  endtask

  initial begin
    logic [OPC_W-1:0] alpha [4];
    logic [HL_W-1:0]  lengths [8];
    logic [IDX_W-1:0] idx;
    logic [OPC_W-1:0] opc;
    int               pick;
    int               glen;

    alpha   = '{6'd0, 6'd1, 6'd42, 6'd63};
    lengths = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_COUNT;
    in_ch.opcode = '0;
    in_ch.read_index = '0;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single opcodes, ignored op code, extreme indexes
    drain_and_set_length(2'd1);
    send_item(OP_COUNT, 6'd0, '0);
    send_item(OP_COUNT, 6'd63, {IDX_W{1'b1}});
    send_item(OP_COUNT, 6'd63, '0);
    send_item(OP_UNUSED, 6'd63, 18'h3ffff);
    send_item(OP_READ, 6'd0, 18'd0);
    send_item(OP_READ, 6'd63, 18'd63);
    send_item(OP_READ, 6'd0, 18'h3ffff);

    // trigrams, zero oldest opcode not counted
    drain_and_set_length(2'd3);
    send_item(OP_START, 6'd21, 18'h2aaaa);
    send_item(OP_COUNT, 6'd5, '0);
    send_item(OP_COUNT, 6'd6, '0);
    send_item(OP_COUNT, 6'd7, '0);
    send_item(OP_READ, 6'd0, {6'd5, 6'd6, 6'd7});
    send_item(OP_READ, 6'd0, {6'd0, 6'd5, 6'd6});

    // length changed without a start, then length zero
    drain_and_set_length(2'd2);
    send_item(OP_COUNT, 6'd63, '0);
    send_item(OP_READ, 6'd42, {6'd0, 6'd7, 6'd63});
    drain_and_set_length(2'd0);
    send_item(OP_COUNT, 6'd0, '0);
    send_item(OP_READ, 6'd0, 18'd0);
    send_item(OP_READ, 6'd0, 18'h15555);
    send_item(OP_START, 6'd0, 18'h15555);
    send_item(OP_COUNT, 6'd42, 18'h2aaaa);
    send_item(OP_READ, 6'd0, 18'd42);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 56; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 56; end
        default: begin sender_idle_pct = 19; stall_pct = 19; end
      endcase
      drain_and_set_length(lengths[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 2 && k == ITEMS_PER_PHASE / 2) begin
          // sender holds off until every read result is back
          in_ch.valid <= 1'b0;
          while (tally.pending() != 0) @(posedge clk);
          @(posedge clk);
        end
        pick = $urandom_range(99);
        opc = ($urandom_range(4) == 0) ? OPC_W'($urandom_range(63))
                                       : alpha[$urandom_range(3)];
        if (pick < 8) begin
          send_item(OP_START, OPC_W'($urandom_range(63)),
                    IDX_W'($urandom_range(STORE_DEPTH - 1)));
        end else if (pick < 11) begin
          send_item(OP_UNUSED, OPC_W'($urandom_range(63)),
                    IDX_W'($urandom_range(STORE_DEPTH - 1)));
        end else if (pick < 35) begin
          if ($urandom_range(9) < 3) begin
            idx = IDX_W'($urandom_range(STORE_DEPTH - 1));
          end else begin
            glen = $urandom_range(1, MAX_HIST);
            idx = '0;
            for (int j = 0; j < glen; j++)
              idx = {idx[IDX_W-OPC_W-1:0], alpha[$urandom_range(3)]};
          end
          send_item(OP_READ, OPC_W'($urandom_range(63)), idx);
        end else begin
          send_item(OP_COUNT, opc, IDX_W'($urandom_range(STORE_DEPTH - 1)));
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d opcode transfers, %0d reads (%0d checked), %0d starts, %0d ignored",
             n_counts, n_reads, tally.reads_checked, n_starts, n_ignored);
    $display("over %0d history length writes in %0d cycles, %0d mismatches",
             n_lengths, cycles, tally.mismatches);
    if (tally.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ngh_pkg.sv
design/ngh_in_if.sv
design/ngh_out_if.sv
design/ngh_ram.sv
design/ngh_ctrl.sv
design/ngh_dp.sv
design/opcode_ngram_histogram_core.sv
sim/opcode_ngram_histogram_core_test.sv
